// ===== sv/jkve_pkg.sv =====
// Shared types, character codes and helpers for the JSON key/value extractor.
package jkve_pkg;

   // Key register file holds sixteen characters, whatever the window depth.
   localparam int KEY_REG_CHARS     = 16;
   localparam int KEY_IDX_W         = $clog2(KEY_REG_CHARS);
   localparam int MAX_KEY_CHARS_DEF = 16;

   // Result queue between the step logic and the response port.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_MODE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CHAR_LIMIT = 3'd4;

   localparam logic [7:0] CHAR_LIMIT_RESET = 8'd255;

   // Character codes.
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_SKIP,
      PH_STRING,
      PH_NUMBER,
      PH_FINISHED
   } phase_type;

   typedef struct packed {
      logic        char_valid;
      logic [7:0]  char_out;
      logic        done_res;
      logic        success;
      logic [31:0] number_value;
   } result_type;

   function automatic logic [7:0] key_char(input logic [2*64-1:0] keys,
                                           input logic [KEY_IDX_W-1:0] idx);
      return keys[8*idx +: 8];
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] c;
      unique case (b)
         CHAR_LOW_N: c = CHAR_LF;
         CHAR_LOW_R: c = CHAR_CR;
         CHAR_LOW_T: c = CHAR_TAB;
         default:    c = b;
      endcase
      return c;
   endfunction

   function automatic result_type make_char(input logic [7:0] c);
      result_type r;
      r              = '0;
      r.char_valid   = 1'b1;
      r.char_out     = c;
      return r;
   endfunction

   function automatic result_type make_done(input logic ok, input logic [31:0] acc);
      result_type r;
      r              = '0;
      r.done_res     = 1'b1;
      r.success      = ok;
      r.number_value = acc;
      return r;
   endfunction

endpackage

// ===== sv/json_key_value_extractor.sv =====
// JSON key/value extractor: key token search, string and number value extraction.
// Results: each result beat is written into the result queue and offered from there.
// Throughput: one text byte per cycle; a byte that causes two results gives two
// response beats, and the request side stalls once the four-entry result queue
// has fewer than two free slots.
// Reset: synchronous, active high; clears document state, queue and registers to defaults.
module json_key_value_extractor #(
   parameter int MAX_KEY_CHARS = jkve_pkg::MAX_KEY_CHARS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // text beats
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_text_byte,
   input  logic                           req_text_end,
   // result beats
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_char_valid,
   output logic [7:0]                     rsp_char_out,
   output logic                           rsp_done_res,
   output logic                           rsp_success,
   output logic [31:0]                    rsp_number_value,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [jkve_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_wdata
);
   import jkve_pkg::*;

   // Window holds ':' at slot 0, then the closing quote, the key reversed and
   // the opening quote.
   localparam int WIN_DEPTH = MAX_KEY_CHARS + 3;
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
   // Wide enough for any slot number and for key_length + 3.
   localparam int CMP_W     = $clog2(WIN_DEPTH + 35);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [63:0] key_low_ff;
   logic [63:0] key_high_ff;
   logic [4:0]  key_length_ff;
   logic        value_mode_ff;
   logic [7:0]  char_limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= '0;
         value_mode_ff <= 1'b0;
         char_limit_ff <= CHAR_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_LOW:    key_low_ff    <= csr_wdata;
            CSR_KEY_HIGH:   key_high_ff   <= csr_wdata;
            CSR_KEY_LENGTH: key_length_ff <= csr_wdata[4:0];
            CSR_VALUE_MODE: value_mode_ff <= csr_wdata[0];
            CSR_CHAR_LIMIT: char_limit_ff <= csr_wdata[7:0];
            default: ;  // writes beyond the register list are dropped
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Document state
   // ---------------------------------------------------------------------
   logic [7:0]        win_ff [WIN_DEPTH];
   logic [7:0]        win_in [WIN_DEPTH];
   logic [FILL_W-1:0] fill_ff, fill_in;
   phase_type         phase_ff, phase_in;
   logic              esc_ff, esc_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [31:0]       acc_ff, acc_in;

   logic              req_accept;
   assign req_accept = req_valid && !req_stall;

   // Window as it stands after shifting in the current byte.
   logic [7:0]        win_shift [WIN_DEPTH];
   logic [FILL_W-1:0] fill_shift;
   logic              token_hit;

   always_comb begin
      win_shift[0] = req_text_byte;
      for (int i = 1; i < WIN_DEPTH; i++) begin
         win_shift[i] = win_ff[i-1];
      end
      fill_shift = (fill_ff < FILL_W'(WIN_DEPTH)) ? FILL_W'(fill_ff + 1'b1) : fill_ff;
   end

   // Parallel compare of the window slots that the token "key": fills against that token.
   always_comb begin
      logic [CMP_W-1:0] len_v;
      logic [CMP_W-1:0] pos_v;
      logic [CMP_W-1:0] kidx_v;
      len_v     = CMP_W'(key_length_ff) + CMP_W'(3);
      pos_v     = '0;
      kidx_v    = '0;
      token_hit = (key_length_ff <= 5'(KEY_REG_CHARS))
               && (CMP_W'(key_length_ff) <= CMP_W'(MAX_KEY_CHARS))
               && (CMP_W'(fill_shift) >= len_v);
      for (int p = 0; p < WIN_DEPTH; p++) begin
         pos_v  = CMP_W'(p);
         kidx_v = len_v - pos_v - CMP_W'(2);
         if (p == 0) begin
            token_hit &= (win_shift[p] == CHAR_COLON);
         end else if (p == 1) begin
            token_hit &= (win_shift[p] == CHAR_QUOTE);
         end else if (pos_v == len_v - CMP_W'(1)) begin
            token_hit &= (win_shift[p] == CHAR_QUOTE);
         end else if (pos_v < len_v - CMP_W'(1)) begin
            token_hit &= (win_shift[p] ==
                          key_char({key_high_ff, key_low_ff}, kidx_v[KEY_IDX_W-1:0]));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Step logic: next document state and up to two results per byte
   // ---------------------------------------------------------------------
   result_type step_res [2];
   logic [1:0] step_count;

   always_comb begin
      logic       is_digit;
      logic [7:0] digit_val;
      logic       ok_v;
      is_digit  = (req_text_byte >= CHAR_ZERO) && (req_text_byte <= CHAR_NINE);
      digit_val = req_text_byte - CHAR_ZERO;
      ok_v      = 1'b0;

      for (int i = 0; i < WIN_DEPTH; i++) begin
         win_in[i] = win_ff[i];
      end
      fill_in     = fill_ff;
      phase_in    = phase_ff;
      esc_in      = esc_ff;
      cnt_in      = cnt_ff;
      acc_in      = acc_ff;
      step_res[0] = '0;
      step_res[1] = '0;
      step_count  = '0;

      unique case (phase_ff)
         PH_SEARCH: begin
            if (req_text_byte == CHAR_NUL) begin
               step_res[step_count[0]] = make_done(1'b0, acc_in);
               step_count              = step_count + 2'd1;
               phase_in                = PH_FINISHED;
            end else begin
               for (int i = 0; i < WIN_DEPTH; i++) begin
                  win_in[i] = win_shift[i];
               end
               fill_in = fill_shift;
               if (token_hit) begin
                  phase_in = PH_SKIP;
               end
            end
         end
         PH_SKIP: begin
            if (req_text_byte == CHAR_SPACE || req_text_byte == CHAR_TAB) begin
               // hold: whitespace between colon and value
            end else if (!value_mode_ff) begin
               if (req_text_byte == CHAR_QUOTE) begin
                  phase_in = PH_STRING;
                  cnt_in   = '0;
                  esc_in   = 1'b0;
               end else begin
                  step_res[step_count[0]] = make_done(1'b0, acc_in);
                  step_count              = step_count + 2'd1;
                  phase_in                = PH_FINISHED;
               end
            end else begin
               if (is_digit) begin
                  acc_in   = 32'(digit_val);
                  phase_in = PH_NUMBER;
               end else begin
                  step_res[step_count[0]] = make_done(1'b0, acc_in);
                  step_count              = step_count + 2'd1;
                  phase_in                = PH_FINISHED;
               end
            end
         end
         PH_STRING: begin
            if (esc_ff) begin
               esc_in = 1'b0;
               if (req_text_byte == CHAR_NUL) begin
                  // backslash right before end of content passes literally
                  step_res[step_count[0]] = make_char(CHAR_BSLASH);
                  step_count              = step_count + 2'd1;
                  step_res[step_count[0]] = make_done(1'b1, acc_in);
                  step_count              = step_count + 2'd1;
                  phase_in                = PH_FINISHED;
               end else begin
                  step_res[step_count[0]] = make_char(unescape(req_text_byte));
                  step_count              = step_count + 2'd1;
                  cnt_in                  = cnt_ff + 8'd1;
                  if (cnt_in >= char_limit_ff) begin
                     step_res[step_count[0]] = make_done(1'b1, acc_in);
                     step_count              = step_count + 2'd1;
                     phase_in                = PH_FINISHED;
                  end
               end
            end else if (cnt_ff >= char_limit_ff) begin
               // limit already reached, e.g. zero limit or limit lowered mid-string
               step_res[step_count[0]] =
                  make_done((cnt_ff != 8'd0) || (req_text_byte == CHAR_QUOTE), acc_in);
               step_count = step_count + 2'd1;
               phase_in   = PH_FINISHED;
            end else if (req_text_byte == CHAR_NUL) begin
               step_res[step_count[0]] = make_done(cnt_ff != 8'd0, acc_in);
               step_count              = step_count + 2'd1;
               phase_in                = PH_FINISHED;
            end else if (req_text_byte == CHAR_QUOTE) begin
               step_res[step_count[0]] = make_done(1'b1, acc_in);
               step_count              = step_count + 2'd1;
               phase_in                = PH_FINISHED;
            end else if (req_text_byte == CHAR_BSLASH) begin
               esc_in = 1'b1;
            end else begin
               step_res[step_count[0]] = make_char(req_text_byte);
               step_count              = step_count + 2'd1;
               cnt_in                  = cnt_ff + 8'd1;
               if (cnt_in >= char_limit_ff) begin
                  step_res[step_count[0]] = make_done(1'b1, acc_in);
                  step_count              = step_count + 2'd1;
                  phase_in                = PH_FINISHED;
               end
            end
         end
         PH_NUMBER: begin
            if (is_digit) begin
               // times ten as two shifts, wrap at 32 bits
               acc_in = (acc_ff << 3) + (acc_ff << 1) + 32'(digit_val);
            end else begin
               step_res[step_count[0]] = make_done(1'b1, acc_in);
               step_count              = step_count + 2'd1;
               phase_in                = PH_FINISHED;
            end
         end
         PH_FINISHED: begin
            // drop: bytes after the done result are ignored
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      // End of document: close out an open value, then clear.
      if (req_text_end) begin
         if (phase_in != PH_FINISHED) begin
            ok_v = 1'b0;
            if (phase_in == PH_NUMBER) begin
               ok_v = 1'b1;
            end else if (phase_in == PH_STRING) begin
               if (esc_in) begin
                  step_res[step_count[0]] = make_char(CHAR_BSLASH);
                  step_count              = step_count + 2'd1;
                  cnt_in                  = cnt_in + 8'd1;
               end
               ok_v = (cnt_in != 8'd0);
            end
            step_res[step_count[0]] = make_done(ok_v, acc_in);
            step_count              = step_count + 2'd1;
         end
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_in[i] = '0;
         end
         fill_in  = '0;
         phase_in = PH_SEARCH;
         esc_in   = 1'b0;
         cnt_in   = '0;
         acc_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= '0;
         end
         fill_ff  <= '0;
         phase_ff <= PH_SEARCH;
         esc_ff   <= 1'b0;
         cnt_ff   <= '0;
         acc_ff   <= '0;
      end else if (req_accept) begin
         for (int i = 0; i < WIN_DEPTH; i++) begin
            win_ff[i] <= win_in[i];
         end
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
      end
   end

   // ---------------------------------------------------------------------
   // Result queue: takes up to two results per accepted byte, hands out one
   // beat per cycle while rsp_stall is low.
   // ---------------------------------------------------------------------
   result_type           rsp_q_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic [1:0]           push_count;
   logic                 rsp_pop;
   result_type           rsp_head;

   assign push_count = req_accept ? step_count : 2'd0;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_pop    = rsp_valid && !rsp_stall;
   // Stall while fewer than two slots are free, so any byte always fits.
   assign req_stall  = (count_ff > RSP_CNT_W'(RSP_DEPTH - 2));

   assign wr_ptr_nx  = wr_ptr_ff + 1'b1;
   assign wr_ptr_in  = wr_ptr_ff + RSP_PTR_W'(push_count);
   assign rd_ptr_in  = rsp_pop ? RSP_PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
   assign count_in   = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(rsp_pop);

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         rsp_q_ff[wr_ptr_ff] <= step_res[0];
      end
      if (push_count == 2'd2) begin
         rsp_q_ff[wr_ptr_nx] <= step_res[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_head         = rsp_q_ff[rd_ptr_ff];
   assign rsp_char_valid   = rsp_head.char_valid;
   assign rsp_char_out     = rsp_head.char_out;
   assign rsp_done_res     = rsp_head.done_res;
   assign rsp_success      = rsp_head.success;
   assign rsp_number_value = rsp_head.number_value;

endmodule
